FILE: hdl/cvpp_pkg.sv
// ----------------------------------------------------------------------------
// cvpp_pkg
// Shared widths, codes, state type, request/response structs and helpers
// for the constant-velocity pose predictor.
// ----------------------------------------------------------------------------
package cvpp_pkg;

    localparam int POS_W  = 32;         // Q16.16 position
    localparam int Q_W    = 32;         // Q2.30 quaternion component
    localparam int Q_FRAC = 30;
    localparam int OPA_W  = 35;         // multiplicand, signed
    localparam int OPB_W  = 32;         // multiplier, signed, consumed bit-serially
    localparam int ACC_W  = 68;         // product and accumulator, signed
    localparam int M_W    = 35;         // magnitude during normalization
    localparam int RAD_W  = 64;         // square-root radicand
    localparam int ROOT_W = 32;         // root and quotient
    localparam int DM_W   = 31;         // normalized magnitude into divider

    localparam logic [1:0] FUNC_PREDICT = 2'd0;
    localparam logic [1:0] FUNC_UPDATE  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    localparam logic signed [Q_W-1:0] Q_ONE  = 32'sh4000_0000;
    localparam logic signed [Q_W-1:0] Q_MONE = 32'shC000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LIN,
        ST_QM_ISS,
        ST_QM_WAIT,
        ST_QM_RND,
        ST_DOT_ISS,
        ST_DOT_WAIT,
        ST_SUM,
        ST_NRM_ABS,
        ST_NRM_CHK,
        ST_SQ_ISS,
        ST_SQ_WAIT,
        ST_SQRT_ISS,
        ST_SQRT_WAIT,
        ST_DIV_ISS,
        ST_DIV_WAIT,
        ST_COMMIT,
        ST_OUT
    } cvpp_state_t;

    typedef struct packed {
        logic                    start;
        logic                    neg;      // extra sign applied to the product
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [ACC_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic              is_div;
        logic [RAD_W-1:0]  rad;
        logic [DM_W-1:0]   m;
        logic [ROOT_W-1:0] n;
    } sd_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] res;
    } sd_rsp_t;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] lo;
        hi = $signed({3'b000, {(POS_W-1){1'b1}}});
        lo = $signed({3'b111, {(POS_W-1){1'b0}}});
        if (v > hi)
            return hi[POS_W-1:0];
        else if (v < lo)
            return lo[POS_W-1:0];
        else
            return v[POS_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] clamp_q(input logic signed [Q_W-1:0] v);
        if (v > Q_ONE)
            return Q_ONE;
        else if (v < Q_MONE)
            return Q_MONE;
        else
            return v;
    endfunction

    // minus signs of the Hamilton product term p[j] * q[i ^ j] in component i
    function automatic logic qm_neg(input logic [1:0] i, input logic [1:0] j);
        case ({i, j})
            4'b0001, 4'b0010, 4'b0011, 4'b0111, 4'b1001, 4'b1110: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

endpackage

FILE: hdl/cvpp_if.sv
// ----------------------------------------------------------------------------
// cvpp_if
// Valid/ready channels for pose beats in and prediction beats out.
// ----------------------------------------------------------------------------
interface cvpp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;

    modport source (output valid, func, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink   (input valid, func, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    output ready);
endinterface

interface cvpp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pred_x;
    logic signed [31:0] pred_y;
    logic signed [31:0] pred_z;
    logic signed [31:0] pred_qw;
    logic signed [31:0] pred_qx;
    logic signed [31:0] pred_qy;
    logic signed [31:0] pred_qz;

    modport source (output valid, pred_x, pred_y, pred_z, pred_qw, pred_qx, pred_qy, pred_qz,
                    input ready);
    modport sink   (input valid, pred_x, pred_y, pred_z, pred_qw, pred_qx, pred_qy, pred_qz,
                    output ready);
endinterface

FILE: hdl/cvpp_mul.sv
// ----------------------------------------------------------------------------
// cvpp_mul
// Sign-magnitude shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cvpp_mul
    import cvpp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam int CNT_W = $clog2(OPB_W);

    logic             busy_reg;
    logic             fin_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [OPA_W-1:0] ma_reg;
    logic [OPA_W-1:0] hi_reg;
    logic [OPB_W-1:0] lo_reg;
    logic signed [ACC_W-1:0] prod_reg;

    logic [OPA_W-1:0] a_u;
    logic [OPB_W-1:0] b_u;
    logic [OPA_W:0]   sum;
    logic [ACC_W-1:0] mag;

    assign a_u = req.a[OPA_W-1] ? (~req.a + 1'b1) : req.a;
    assign b_u = req.b[OPB_W-1] ? (~req.b + 1'b1) : req.b;
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, ma_reg} : '0);
    assign mag = {1'b0, hi_reg, lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg && fin_reg)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(OPB_W - 1))
                    fin_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            ma_reg  <= a_u;
            lo_reg  <= b_u;
            hi_reg  <= '0;
            neg_reg <= req.a[OPA_W-1] ^ req.b[OPB_W-1] ^ req.neg;
        end
        else if (busy_reg && fin_reg)
        begin
            prod_reg <= neg_reg ? -$signed(mag) : $signed(mag);
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[OPA_W:1];
            lo_reg <= {sum[0], lo_reg[OPB_W-1:1]};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;

endmodule

FILE: hdl/cvpp_sqdiv.sv
// ----------------------------------------------------------------------------
// cvpp_sqdiv
// Restoring square root (two radicand bits a cycle) and rounded divide
// (one quotient bit a cycle) sharing one remainder and shift register.
// ----------------------------------------------------------------------------
module cvpp_sqdiv
    import cvpp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  sd_req_t req,
    output sd_rsp_t rsp
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 1;

    logic              busy_reg;
    logic              done_reg;
    logic              div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RAD_W-1:0]  x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] n_reg;

    logic [RAD_W-1:0]  num;
    logic [REM_W+1:0]  sq_sh;
    logic [REM_W+1:0]  sq_trial;
    logic [REM_W:0]    dv_sh;
    logic              sq_ge;
    logic              dv_ge;

    assign num      = {3'b000, req.m, {Q_FRAC{1'b0}}} + {33'd0, req.n[ROOT_W-1:1]};
    assign sq_sh    = {rem_reg, x_reg[RAD_W-1:RAD_W-2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign dv_sh    = {rem_reg, x_reg[RAD_W-1]};
    assign dv_ge    = dv_sh >= {2'b00, n_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            div_reg  <= req.is_div;
            n_reg    <= req.n;
            root_reg <= '0;
            if (req.is_div)
            begin
                rem_reg <= {3'b000, num[RAD_W-3:ROOT_W]};
                x_reg   <= {num[ROOT_W-1:0], {ROOT_W{1'b0}}};
            end
            else
            begin
                rem_reg <= '0;
                x_reg   <= req.rad;
            end
        end
        else if (busy_reg && div_reg)
        begin
            x_reg <= {x_reg[RAD_W-2:0], 1'b0};
            if (dv_ge)
            begin
                rem_reg  <= REM_W'(dv_sh - {2'b00, n_reg});
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= dv_sh[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[RAD_W-3:0], 2'b00};
            if (sq_ge)
            begin
                rem_reg  <= REM_W'(sq_sh - sq_trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= sq_sh[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = root_reg;

endmodule

FILE: hdl/constant_velocity_pose_predictor.sv
// ----------------------------------------------------------------------------
// constant_velocity_pose_predictor
// Work: each predict/update beat is paced by the shared bit-serial multiplier
//   (up to 44 products) plus one square root and four divides per normalization,
//   plus one normalization shift step each time the magnitudes are out of range.
//   Clear skips the arithmetic and goes straight to the output stage.
// Throughput: one beat at a time; the next pose is taken as soon as the result
//   sits in the output register. Reset: zero velocity, identity orientations.
// ----------------------------------------------------------------------------
module constant_velocity_pose_predictor
    import cvpp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    cvpp_in_if.sink    pose_in,
    cvpp_out_if.source pose_out
);

    // Flow of one predict/update beat:
    //   LIN      : smoothed velocity and predicted position, one axis at a time
    //   QM pass0 : d = q * conj(prev), 16 serial products, rounded per component
    //   DOT/SUM  : sign of sum(d*a/4) picks d+a or d-a
    //   NRM      : shift magnitudes into [2^30,2^31), sum squares, sqrt, 4 divides
    //   QM pass1 : r = q * nav, then NRM again gives the output quaternion
    //   COMMIT   : update stores the new state

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd536870912);

    cvpp_state_t state_reg, state_next;

    logic [1:0] i_reg;      // output component of the quaternion product
    logic [1:0] j_reg;      // term / lane counter, wraps after four
    logic [1:0] k_reg;      // position axis
    logic       ph_reg;
    logic       pass_reg;
    logic       ov_reg;

    logic signed [POS_W-1:0] prev_pos_reg [3];
    logic signed [POS_W-1:0] lin_vel_reg  [3];
    logic signed [Q_W-1:0]   prev_q_reg   [4];
    logic signed [Q_W-1:0]   ang_v_reg    [4];

    logic [1:0]              func_reg;
    logic signed [POS_W-1:0] pos_reg  [3];
    logic signed [POS_W-1:0] nlin_reg [3];
    logic signed [POS_W-1:0] pred_reg [3];
    logic signed [Q_W-1:0]   quat_reg [4];
    logic signed [Q_W-1:0]   nav_reg  [4];
    logic signed [Q_W-1:0]   res_q_reg[4];
    logic signed [OPA_W-1:0] d_reg    [4];
    logic signed [M_W-1:0]   c_reg    [4];
    logic [M_W-1:0]          m_reg    [4];
    logic [3:0]              neg_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ROOT_W-1:0]       n_reg;
    logic signed [POS_W-1:0] opos_reg [3];
    logic signed [Q_W-1:0]   oq_reg   [4];

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    sd_req_t  sd_req;
    sd_rsp_t  sd_rsp;

    logic                    in_fire;
    logic                    out_load;
    logic [1:0]              k_idx;
    logic [M_W-1:0]          or_all;
    logic                    nrm_zero;
    logic                    shift_r;
    logic                    shift_l;
    logic                    dot_pos;
    logic signed [ACC_W-1:0] rnd;
    logic signed [POS_W+1:0] lin_sum;
    logic signed [POS_W+1:0] pred_sum;
    logic signed [Q_W-1:0]   div_val;

    assign in_fire  = pose_in.valid && pose_in.ready;
    assign out_load = (state_reg == ST_OUT) && (!ov_reg || pose_out.ready);
    assign k_idx    = i_reg ^ j_reg;
    assign or_all   = m_reg[0] | m_reg[1] | m_reg[2] | m_reg[3];
    assign nrm_zero = (or_all == '0);
    assign shift_r  = |or_all[M_W-1:ROOT_W-1];
    assign shift_l  = !or_all[Q_FRAC];
    assign dot_pos  = !acc_reg[ACC_W-1];
    assign rnd      = (acc_reg + RND_HALF) >>> Q_FRAC;
    assign lin_sum  = $signed({{2{pos_reg[k_reg][POS_W-1]}}, pos_reg[k_reg]})
                    - $signed({{2{prev_pos_reg[k_reg][POS_W-1]}}, prev_pos_reg[k_reg]})
                    + $signed({{2{lin_vel_reg[k_reg][POS_W-1]}}, lin_vel_reg[k_reg]});
    assign pred_sum = $signed({{2{pos_reg[k_reg][POS_W-1]}}, pos_reg[k_reg]})
                    + $signed({{2{nlin_reg[k_reg][POS_W-1]}}, nlin_reg[k_reg]});
    assign div_val  = neg_reg[j_reg] ? -$signed(sd_rsp.res) : $signed(sd_rsp.res);

    assign pose_in.ready = (state_reg == ST_IDLE);

    cvpp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    cvpp_sqdiv u_sqdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sd_req),
        .rsp   (sd_rsp)
    );

    // next state and unit requests
    always_comb
    begin
        state_next     = state_reg;
        mul_req.start  = 1'b0;
        mul_req.neg    = 1'b0;
        mul_req.a      = $signed({{(OPA_W-Q_W){quat_reg[j_reg][Q_W-1]}}, quat_reg[j_reg]});
        mul_req.b      = pass_reg ? nav_reg[k_idx] : prev_q_reg[k_idx];
        sd_req.start   = 1'b0;
        sd_req.is_div  = 1'b0;
        sd_req.rad     = acc_reg[RAD_W-1:0];
        sd_req.m       = m_reg[j_reg][DM_W-1:0];
        sd_req.n       = n_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = (pose_in.func == FUNC_CLEAR) ? ST_OUT : ST_LIN;
            end
            ST_LIN:
            begin
                if (ph_reg && k_reg == 2'd2)
                    state_next = ST_QM_ISS;
            end
            ST_QM_ISS:
            begin
                mul_req.start = 1'b1;
                mul_req.neg   = qm_neg(i_reg, j_reg) ^ (!pass_reg && k_idx != 2'd0);
                state_next    = ST_QM_WAIT;
            end
            ST_QM_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = (j_reg == 2'd3) ? ST_QM_RND : ST_QM_ISS;
            end
            ST_QM_RND:
            begin
                if (i_reg != 2'd3)
                    state_next = ST_QM_ISS;
                else
                    state_next = pass_reg ? ST_NRM_ABS : ST_DOT_ISS;
            end
            ST_DOT_ISS:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = d_reg[j_reg];
                mul_req.b     = ang_v_reg[j_reg];
                state_next    = ST_DOT_WAIT;
            end
            ST_DOT_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = (j_reg == 2'd3) ? ST_SUM : ST_DOT_ISS;
            end
            ST_SUM:     state_next = ST_NRM_ABS;
            ST_NRM_ABS: state_next = ST_NRM_CHK;
            ST_NRM_CHK:
            begin
                if (nrm_zero)
                    state_next = pass_reg ? ST_COMMIT : ST_QM_ISS;
                else if (!shift_r && !shift_l)
                    state_next = ST_SQ_ISS;
            end
            ST_SQ_ISS:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = $signed(m_reg[j_reg]);
                mul_req.b     = $signed(m_reg[j_reg][OPB_W-1:0]);
                state_next    = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = (j_reg == 2'd3) ? ST_SQRT_ISS : ST_SQ_ISS;
            end
            ST_SQRT_ISS:
            begin
                sd_req.start = 1'b1;
                state_next   = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (sd_rsp.done)
                    state_next = ST_DIV_ISS;
            end
            ST_DIV_ISS:
            begin
                sd_req.start  = 1'b1;
                sd_req.is_div = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (sd_rsp.done)
                begin
                    if (j_reg != 2'd3)
                        state_next = ST_DIV_ISS;
                    else
                        state_next = pass_reg ? ST_COMMIT : ST_QM_ISS;
                end
            end
            ST_COMMIT: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // counters, output valid and the tracked motion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
            ph_reg   <= 1'b0;
            pass_reg <= 1'b0;
            ov_reg   <= 1'b0;
            for (int n = 0; n < 3; n++)
            begin
                prev_pos_reg[n] <= '0;
                lin_vel_reg[n]  <= '0;
            end
            for (int n = 0; n < 4; n++)
            begin
                prev_q_reg[n] <= (n == 0) ? Q_ONE : '0;
                ang_v_reg[n]  <= (n == 0) ? Q_ONE : '0;
            end
        end
        else
        begin
            if (out_load)
                ov_reg <= 1'b1;
            else if (pose_out.ready)
                ov_reg <= 1'b0;

            if (in_fire)
            begin
                i_reg    <= '0;
                j_reg    <= '0;
                k_reg    <= '0;
                ph_reg   <= 1'b0;
                pass_reg <= 1'b0;
                if (pose_in.func == FUNC_CLEAR)
                begin
                    for (int n = 0; n < 3; n++)
                    begin
                        prev_pos_reg[n] <= '0;
                        lin_vel_reg[n]  <= '0;
                    end
                    for (int n = 0; n < 4; n++)
                    begin
                        prev_q_reg[n] <= (n == 0) ? Q_ONE : '0;
                        ang_v_reg[n]  <= (n == 0) ? Q_ONE : '0;
                    end
                end
            end

            if (state_reg == ST_LIN)
            begin
                ph_reg <= !ph_reg;
                if (ph_reg)
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
            end

            if (mul_rsp.done || (state_reg == ST_DIV_WAIT && sd_rsp.done))
                j_reg <= j_reg + 2'd1;

            if (state_reg == ST_QM_RND)
                i_reg <= i_reg + 2'd1;

            // pass 0 normalization done: second product follows
            if (!pass_reg && ((state_reg == ST_NRM_CHK && nrm_zero)
                || (state_reg == ST_DIV_WAIT && sd_rsp.done && j_reg == 2'd3)))
                pass_reg <= 1'b1;

            if (state_reg == ST_COMMIT && func_reg == FUNC_UPDATE)
            begin
                for (int n = 0; n < 3; n++)
                begin
                    prev_pos_reg[n] <= pos_reg[n];
                    lin_vel_reg[n]  <= nlin_reg[n];
                end
                for (int n = 0; n < 4; n++)
                begin
                    prev_q_reg[n] <= quat_reg[n];
                    ang_v_reg[n]  <= nav_reg[n];
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    func_reg    <= pose_in.func;
                    pos_reg[0]  <= pose_in.pos_x;
                    pos_reg[1]  <= pose_in.pos_y;
                    pos_reg[2]  <= pose_in.pos_z;
                    quat_reg[0] <= clamp_q(pose_in.quat_w);
                    quat_reg[1] <= clamp_q(pose_in.quat_x);
                    quat_reg[2] <= clamp_q(pose_in.quat_y);
                    quat_reg[3] <= clamp_q(pose_in.quat_z);
                    for (int n = 0; n < 3; n++)
                        pred_reg[n] <= '0;
                    for (int n = 0; n < 4; n++)
                        res_q_reg[n] <= (n == 0) ? Q_ONE : '0;
                end
            end
            ST_LIN:
            begin
                if (!ph_reg)
                    nlin_reg[k_reg] <= sat_pos(lin_sum >>> 1);
                else
                    pred_reg[k_reg] <= sat_pos(pred_sum);
                acc_reg <= '0;
            end
            ST_QM_WAIT, ST_SQ_WAIT:
            begin
                if (mul_rsp.done)
                    acc_reg <= acc_reg + mul_rsp.prod;
            end
            ST_QM_RND:
            begin
                if (pass_reg)
                    c_reg[i_reg] <= rnd[M_W-1:0];
                else
                    d_reg[i_reg] <= rnd[OPA_W-1:0];
                acc_reg <= '0;
            end
            ST_DOT_WAIT:
            begin
                if (mul_rsp.done)
                    acc_reg <= acc_reg + (mul_rsp.prod >>> 2);
            end
            ST_SUM:
            begin
                for (int n = 0; n < 4; n++)
                begin
                    if (dot_pos)
                        c_reg[n] <= d_reg[n]
                                  + $signed({{(M_W-Q_W){ang_v_reg[n][Q_W-1]}}, ang_v_reg[n]});
                    else
                        c_reg[n] <= d_reg[n]
                                  - $signed({{(M_W-Q_W){ang_v_reg[n][Q_W-1]}}, ang_v_reg[n]});
                end
                acc_reg <= '0;
            end
            ST_NRM_ABS:
            begin
                for (int n = 0; n < 4; n++)
                begin
                    neg_reg[n] <= c_reg[n][M_W-1];
                    m_reg[n]   <= c_reg[n][M_W-1] ? (~c_reg[n] + 1'b1) : c_reg[n];
                end
            end
            ST_NRM_CHK:
            begin
                if (nrm_zero)
                begin
                    // zero vector normalizes to identity
                    for (int n = 0; n < 4; n++)
                    begin
                        if (pass_reg)
                            res_q_reg[n] <= (n == 0) ? Q_ONE : '0;
                        else
                            nav_reg[n] <= (n == 0) ? Q_ONE : '0;
                    end
                end
                else if (shift_r)
                begin
                    for (int n = 0; n < 4; n++)
                        m_reg[n] <= m_reg[n] >> 1;
                end
                else if (shift_l)
                begin
                    for (int n = 0; n < 4; n++)
                        m_reg[n] <= m_reg[n] << 1;
                end
                acc_reg <= '0;
            end
            ST_SQRT_WAIT:
            begin
                if (sd_rsp.done)
                begin
                    n_reg   <= sd_rsp.res;
                    acc_reg <= '0;
                end
            end
            ST_DIV_WAIT:
            begin
                if (sd_rsp.done)
                begin
                    if (pass_reg)
                        res_q_reg[j_reg] <= div_val;
                    else
                        nav_reg[j_reg] <= div_val;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    for (int n = 0; n < 3; n++)
                        opos_reg[n] <= pred_reg[n];
                    for (int n = 0; n < 4; n++)
                        oq_reg[n] <= res_q_reg[n];
                end
            end
            default: ;
        endcase
    end

    assign pose_out.valid   = ov_reg;
    assign pose_out.pred_x  = opos_reg[0];
    assign pose_out.pred_y  = opos_reg[1];
    assign pose_out.pred_z  = opos_reg[2];
    assign pose_out.pred_qw = oq_reg[0];
    assign pose_out.pred_qx = oq_reg[1];
    assign pose_out.pred_qy = oq_reg[2];
    assign pose_out.pred_qz = oq_reg[3];

    // a new product is never requested while the multiplier is still running
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    // squares are only taken once the largest magnitude sits in [2^30, 2^31)
    a_nrm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ_ISS) |-> (!shift_r && !shift_l))
        else $error("normalization shift incomplete");

    // divisor is a nonzero root
    a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (sd_req.start && sd_req.is_div) |-> (sd_req.n != '0))
        else $error("divide by zero root");

    // clear goes straight to the output stage
    a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pose_in.func == FUNC_CLEAR) |=> (state_reg == ST_OUT))
        else $error("clear beat did not go to output");

endmodule
